// ----- sv/esched_pkg.sv -----
package esched_pkg;

  typedef struct packed {
    logic [7:0] floor;
    logic [1:0] dir;
  } entry_t;

  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DN   = 2'b11;

  localparam logic [2:0] EV_MOVED  = 3'd0;
  localparam logic [2:0] EV_IDLE   = 3'd1;
  localparam logic [2:0] EV_SERVED = 3'd2;
  localparam logic [2:0] EV_AT_CAR = 3'd3;
  localparam logic [2:0] EV_DUP    = 3'd4;
  localparam logic [2:0] EV_QUEUED = 3'd5;
  localparam logic [2:0] EV_FULL   = 3'd6;

  localparam int MAX_RESULTS = 16;

  // sign of the product of two direction codes
  function automatic logic [1:0] dsign(input logic [1:0] a, input logic [1:0] b);
    if (a == DIR_NONE || b == DIR_NONE) dsign = DIR_NONE;
    else if (a == b) dsign = DIR_UP;
    else dsign = DIR_DN;
  endfunction

  // fl*a >= fl*b
  function automatic logic fl_ge(input logic [1:0] fl, input logic [7:0] a,
                                 input logic [7:0] b);
    if (fl == DIR_UP) fl_ge = (a >= b);
    else if (fl == DIR_NONE) fl_ge = 1'b1;
    else fl_ge = (a <= b);
  endfunction

  // fl*a > fl*b
  function automatic logic fl_gt(input logic [1:0] fl, input logic [7:0] a,
                                 input logic [7:0] b);
    if (fl == DIR_UP) fl_gt = (a > b);
    else if (fl == DIR_NONE) fl_gt = 1'b0;
    else fl_gt = (a < b);
  endfunction

endpackage

// ----- sv/esched_queue.sv -----
module esched_queue import esched_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [IW-1:0] rd_idx,
  output entry_t        rd_data,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_idx,
  input  entry_t        wr_data,
  input  logic          pop
);

  localparam logic [IW:0] DEPTH_W = (IW+1)'(DEPTH);

  entry_t mem [DEPTH];
  logic [IW-1:0] head;

  // ring buffer: logical index -> physical address
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [IW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= DEPTH_W) s = s - DEPTH_W;
    phys = s[IW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else if (pop) begin
      head <= phys(head, IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[phys(head, wr_idx)] <= wr_data;
    end
    rd_data <= mem[phys(head, rd_idx)];
  end

endmodule

// ----- sv/elevator_stop_scheduler.sv -----
// Elevator stop scheduler. Pending stops live in a QUEUE_DEPTH-entry ring
// memory (registered read); all work walks it one entry at a time, one item
// in flight. A request scans the queued entries for a duplicate, then scans
// for its slot and moves the entries behind the slot up to open it.
// A tick looks ahead over the stops at the car's floor, then pops each
// stop and sends its beat; otherwise it moves the car or reports idle.
// Served stops leave one result beat each. The output register lets a new
// item in while the last result of the previous one still waits.
module elevator_stop_scheduler import esched_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_FLOOR = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // req_floor[7:0], req_dir[9:8]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // event_floor[7:0], event_dir[9:8], car_floor[17:10],
                                 // travel_dir[19:18]
  output logic [2:0]  m_tuser,   // event_res
  output logic        m_tlast
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam int MFC = (MAX_FLOOR > 255) ? 255 : MAX_FLOOR;
  localparam logic [7:0] MF8 = 8'(MFC);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_SCAN_RD = 11'b00000000010,
    ST_SCAN_EV = 11'b00000000100,
    ST_CHK     = 11'b00000001000,
    ST_SH_RD   = 11'b00000010000,
    ST_SH_WR   = 11'b00000100000,
    ST_TK_RD   = 11'b00001000000,
    ST_TK_EV   = 11'b00010000000,
    ST_POP_RD  = 11'b00100000000,
    ST_POP_EV  = 11'b01000000000,
    ST_EMIT    = 11'b10000000000
  } state_t;

  typedef enum logic [5:0] {
    PH_DUP = 6'b000001,
    PH_P1  = 6'b000010,
    PH_A   = 6'b000100,
    PH_B   = 6'b001000,
    PH_C   = 6'b010000,
    PH_D   = 6'b100000
  } phase_t;

  state_t state;
  phase_t ph;
  logic          c3;
  logic          have_pos;
  logic          capped;
  logic [CW-1:0] p, pos, cnt, n, k;
  logic [7:0]    x, car_pos;
  logic [1:0]    d, car_dir;
  logic          popping;
  logic [2:0]    pres;
  logic [7:0]    pfloor;
  logic [1:0]    pdir;
  logic          plast;

  entry_t        ent;
  logic [IW-1:0] rd_idx, wr_idx;
  logic          wr_en, pop;
  entry_t        wr_data;

  logic slot_free, cond;
  logic [7:0] in_floor;
  logic [1:0] in_dir;
  logic [CW-1:0] p_inc;

  assign slot_free = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);
  assign in_floor  = (s_tdata[7:0] > MF8) ? MF8 : s_tdata[7:0];
  assign in_dir    = (s_tdata[9:8] == 2'b00) ? DIR_NONE :
                     (s_tdata[9:8] == 2'b01) ? DIR_UP : DIR_DN;
  assign p_inc     = p + CW'(1);
  assign pop       = (state == ST_EMIT) && slot_free && popping;

  esched_queue #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_queue (
    .clk(clk), .rst(rst), .rd_idx(rd_idx), .rd_data(ent),
    .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data), .pop(pop)
  );

  always_comb begin
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = pos[IW-1:0];
    wr_data = '{floor: x, dir: d};
    unique case (state)
      ST_SCAN_RD, ST_SCAN_EV, ST_TK_RD, ST_TK_EV: rd_idx = p[IW-1:0];
      ST_SH_RD: begin
        rd_idx = IW'(p - CW'(1));
        wr_en  = (p == pos);
      end
      ST_SH_WR: begin
        wr_en   = 1'b1;
        wr_idx  = p[IW-1:0];
        wr_data = ent;
      end
      default: rd_idx = '0;
    endcase
  end

  // scan condition of the current phase on the entry just read
  always_comb begin
    unique case (ph)
      PH_DUP: cond = (ent.floor != x);
      PH_P1:  cond = fl_ge(car_dir, ent.floor, car_pos) && fl_gt(car_dir, x, ent.floor) &&
                     (dsign(car_dir, ent.dir) != DIR_DN);
      PH_A:   cond = fl_ge(car_dir, ent.floor, car_pos) && (dsign(car_dir, ent.dir) != DIR_DN);
      PH_B:   cond = (dsign(ent.dir, car_dir) != DIR_UP) && fl_gt(car_dir, ent.floor, x);
      PH_C:   cond = (dsign(ent.dir, car_dir) != DIR_UP);
      PH_D:   cond = (dsign(ent.dir, car_dir) != DIR_DN) && fl_gt(car_dir, x, ent.floor);
      default: cond = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      car_pos  <= 8'd1;
      car_dir  <= DIR_NONE;
      m_tvalid <= 1'b0;
      ph       <= PH_DUP;
      popping  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (cfg_we) car_pos <= (cfg_wdata > MF8) ? MF8 : cfg_wdata;
          if (s_tvalid) begin
            x        <= in_floor;
            d        <= in_dir;
            p        <= '0;
            ph       <= PH_DUP;
            have_pos <= 1'b0;
            capped   <= 1'b0;
            popping  <= 1'b0;
            plast    <= 1'b1;
            if (!s_tuser) begin
              if (in_floor == car_pos) begin
                pres   <= EV_AT_CAR;
                pfloor <= in_floor;
                pdir   <= in_dir;
                state  <= ST_EMIT;
              end else begin
                state <= ST_SCAN_RD;
              end
            end else if (cnt == '0) begin
              car_dir <= DIR_NONE;
              pres    <= EV_IDLE;
              pfloor  <= '0;
              pdir    <= DIR_NONE;
              state   <= ST_EMIT;
            end else begin
              state <= ST_TK_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          if (p == cnt) begin
            if (ph == PH_DUP) begin
              state <= ST_CHK;
            end else begin
              pos   <= p;
              p     <= cnt;
              state <= ST_SH_RD;
            end
          end else begin
            state <= ST_SCAN_EV;
          end
        end
        ST_SCAN_EV: begin
          if (cond) begin
            p     <= p_inc;
            state <= ST_SCAN_RD;
          end else begin
            unique case (ph)
              PH_DUP: begin
                if (ent.dir == d) begin
                  pres   <= EV_DUP;
                  pfloor <= x;
                  pdir   <= d;
                  state  <= ST_EMIT;
                end else begin
                  if (dsign(car_dir, d) == DIR_DN) begin
                    pos      <= p_inc;
                    have_pos <= 1'b1;
                  end
                  state <= ST_CHK;
                end
              end
              PH_A: ph <= c3 ? PH_C : PH_B;
              PH_C: ph <= PH_D;
              default: begin
                pos   <= p;
                p     <= cnt;
                state <= ST_SH_RD;
              end
            endcase
          end
        end
        ST_CHK: begin
          if (cnt == DEPTH_C) begin
            pres   <= EV_FULL;
            pfloor <= x;
            pdir   <= d;
            state  <= ST_EMIT;
          end else if (have_pos) begin
            p     <= cnt;
            state <= ST_SH_RD;
          end else begin
            p     <= '0;
            state <= ST_SCAN_RD;
            if (fl_gt(car_dir, x, car_pos) && dsign(d, car_dir) != DIR_DN) begin
              ph <= PH_P1;
            end else begin
              ph <= PH_A;
              c3 <= (dsign(d, car_dir) == DIR_UP);
            end
          end
        end
        ST_SH_RD: begin
          if (p == pos) begin
            cnt    <= cnt + CW'(1);
            pres   <= EV_QUEUED;
            pfloor <= x;
            pdir   <= d;
            state  <= ST_EMIT;
          end else begin
            state <= ST_SH_WR;
          end
        end
        ST_SH_WR: begin
          p     <= p - CW'(1);
          state <= ST_SH_RD;
        end
        ST_TK_RD: state <= ST_TK_EV;
        ST_TK_EV: begin
          if (capped) begin
            // entry after the served batch sets the direction
            car_dir <= (car_pos > ent.floor) ? DIR_DN : DIR_UP;
            n       <= p;
            k       <= '0;
            state   <= ST_POP_RD;
          end else if (ent.floor == car_pos) begin
            // look ahead over the stops at this floor before popping any
            p <= p_inc;
            if (p_inc == cnt) begin
              car_dir <= DIR_NONE;
              n       <= p_inc;
              k       <= '0;
              state   <= ST_POP_RD;
            end else if (32'(p_inc) == MAX_RESULTS) begin
              capped <= 1'b1;
              state  <= ST_TK_RD;
            end else begin
              state <= ST_TK_RD;
            end
          end else if (p == '0) begin
            car_dir <= (car_pos > ent.floor) ? DIR_DN : DIR_UP;
            car_pos <= (car_pos > ent.floor) ? car_pos - 8'd1 : car_pos + 8'd1;
            pres    <= EV_MOVED;
            pfloor  <= ent.floor;
            pdir    <= ent.dir;
            state   <= ST_EMIT;
          end else begin
            car_dir <= (car_pos > ent.floor) ? DIR_DN : DIR_UP;
            n       <= p;
            k       <= '0;
            state   <= ST_POP_RD;
          end
        end
        ST_POP_RD: state <= ST_POP_EV;
        ST_POP_EV: begin
          pres    <= EV_SERVED;
          pfloor  <= ent.floor;
          pdir    <= ent.dir;
          plast   <= (k + CW'(1) == n);
          popping <= 1'b1;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= pres;
            m_tlast  <= plast;
            m_tdata  <= {4'b0, car_dir, car_pos, pdir, pfloor};
            if (popping) begin
              cnt <= cnt - CW'(1);
              k   <= k + CW'(1);
              state <= plast ? ST_IDLE : ST_POP_RD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/tb_elevator_stop_scheduler.sv -----
module tb_elevator_stop_scheduler;
  import esched_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [2:0] res;
    logic [7:0] floor;
    logic [1:0] dir;
    logic [7:0] car;
    logic [1:0] tdir;
    logic       last;
  } event_t;

  typedef struct {
    bit       tick;
    bit [7:0] floor;
    bit [1:0] dcode;
    int       want;     // first event code, -1 when left to the scheduler model
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  elevator_stop_scheduler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // scheduler state mirror
  int stop_fl [DEPTH];
  int stop_dr [DEPTH];
  int stop_len = 0;
  int car_pos = 1;
  int car_dir = 0;

  event_t pending_events[$];
  int errors = 0;
  int n_items = 0, n_beats = 0, n_full = 0, n_served = 0, n_moves = 0;
  bit no_idle = 1'b0;
  bit hold_sink = 1'b0;

  function automatic int code_to_dir(logic [1:0] c);
    if (c == DIR_UP) return 1;
    if (c == DIR_NONE) return 0;
    return -1;
  endfunction

  function automatic logic [1:0] dir_to_code(int d);
    if (d > 0) return DIR_UP;
    if (d < 0) return DIR_DN;
    return DIR_NONE;
  endfunction

  function automatic int slot_for(int x, int d);
    int fl, p;
    fl = car_dir;
    p = 0;
    if (fl * (x - car_pos) > 0 && d * fl >= 0) begin
      while (p < stop_len && fl * stop_fl[p] >= fl * car_pos && fl * stop_fl[p] < fl * x &&
             fl * stop_dr[p] >= 0) p++;
    end else if (d * fl <= 0) begin
      while (p < stop_len && fl * stop_fl[p] >= fl * car_pos && fl * stop_dr[p] >= 0) p++;
      while (p < stop_len && stop_dr[p] * fl <= 0 && fl * stop_fl[p] > fl * x) p++;
    end else begin
      while (p < stop_len && fl * stop_fl[p] >= fl * car_pos && fl * stop_dr[p] >= 0) p++;
      while (p < stop_len && stop_dr[p] * fl <= 0) p++;
      while (p < stop_len && stop_dr[p] * fl >= 0 && fl * x > fl * stop_fl[p]) p++;
    end
    return p;
  endfunction

  // advance the mirror by one beat and queue the events it causes; returns first code
  function automatic int schedule_step(bit tick, logic [7:0] fl_in, logic [1:0] dc);
    int x, d, n, pos, i;
    bit found, done;
    int rr [DEPTH];
    int rf [DEPTH];
    int rd [DEPTH];
    event_t ev;
    n = 0;
    done = 1'b0;
    found = 1'b0;
    pos = 0;
    if (!tick) begin
      x = fl_in;
      d = code_to_dir(dc);
      rf[0] = x; rd[0] = d; n = 1;
      if (x == car_pos) begin
        rr[0] = EV_AT_CAR; done = 1'b1;
      end
      for (i = 0; !done && i < stop_len; i++)
        if (stop_fl[i] == x) begin
          if (stop_dr[i] == d) begin
            rr[0] = EV_DUP; done = 1'b1;
          end else if (car_dir * d < 0) begin
            pos = i + 1; found = 1'b1;
          end
          break;
        end
      if (!done && stop_len >= DEPTH) begin
        rr[0] = EV_FULL; done = 1'b1;
      end
      if (!done) begin
        if (!found) pos = slot_for(x, d);
        if (pos > stop_len) pos = stop_len;
        for (i = stop_len; i > pos; i--) begin
          stop_fl[i] = stop_fl[i-1];
          stop_dr[i] = stop_dr[i-1];
        end
        stop_fl[pos] = x;
        stop_dr[pos] = d;
        stop_len++;
        rr[0] = EV_QUEUED;
      end
    end else if (stop_len == 0) begin
      car_dir = 0;
      rr[0] = EV_IDLE; rf[0] = 0; rd[0] = 0; n = 1;
    end else if (stop_fl[0] == car_pos) begin
      while (stop_len > 0 && stop_fl[0] == car_pos && n < MAX_RESULTS) begin
        rr[n] = EV_SERVED; rf[n] = stop_fl[0]; rd[n] = stop_dr[0]; n++;
        for (i = 0; i < stop_len - 1; i++) begin
          stop_fl[i] = stop_fl[i+1];
          stop_dr[i] = stop_dr[i+1];
        end
        stop_len--;
      end
      car_dir = (stop_len == 0) ? 0 : (car_pos > stop_fl[0] ? -1 : 1);
    end else begin
      car_dir = car_pos > stop_fl[0] ? -1 : 1;
      car_pos = car_pos + car_dir;
      rr[0] = EV_MOVED; rf[0] = stop_fl[0]; rd[0] = stop_dr[0]; n = 1;
    end
    for (i = 0; i < n; i++) begin
      ev.res = rr[i][2:0];
      ev.floor = rf[i][7:0];
      ev.dir = dir_to_code(rd[i]);
      ev.car = car_pos[7:0];
      ev.tdir = dir_to_code(car_dir);
      ev.last = (i == n - 1);
      pending_events.push_back(ev);
      if (rr[i] == EV_SERVED) n_served++;
      if (rr[i] == EV_FULL) n_full++;
      if (rr[i] == EV_MOVED) n_moves++;
    end
    return rr[0];
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(bit tick, logic [7:0] fl, logic [1:0] dc, int want);
    int g, got;
    s_tvalid <= 1'b1;
    s_tuser <= tick;
    s_tdata <= {6'd0, dc, fl};
    do @(posedge clk); while (!s_tready);
    got = schedule_step(tick, fl, dc);
    n_items++;
    if (want >= 0 && got != want) begin
      errors++;
      if (errors <= 10) $display("directed row: event code %0d, table says %0d", got, want);
    end
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic set_start_floor(logic [7:0] v);
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    car_pos = v;
  endtask

  task automatic request_near();
    int f;
    if ($urandom_range(0, 19) == 0) f = $urandom_range(0, 255);
    else f = car_pos + $urandom_range(0, 16) - 8;
    if (f < 0) f = 0;
    if (f > 255) f = 255;
    send(1'b0, f[7:0], 2'($urandom_range(0, 3)), -1);
  endtask

  // a few calls then ticks until the car has worked them off (bounded)
  task automatic trip();
    int k;
    repeat ($urandom_range(1, 5)) request_near();
    k = 0;
    while (stop_len > 0 && k < 60) begin
      if ($urandom_range(0, 7) == 0) request_near();
      send(1'b1, 8'($urandom), 2'($urandom), -1);
      k++;
    end
    send(1'b1, 8'($urandom), 2'($urandom), -1);
  endtask

  task automatic fill_queue();
    int base;
    base = (car_pos > 200) ? car_pos - 40 : car_pos + 20;
    for (int i = 0; i < DEPTH + 3; i++)
      send(1'b0, 8'(base + i), 2'($urandom_range(0, 3)), -1);
    repeat ($urandom_range(0, 3)) send(1'b0, 8'(base + 1), 2'($urandom_range(0, 3)), -1);
  endtask

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      m_tready <= 1'b1;
      @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    event_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.res = m_tuser;
      got.floor = m_tdata[7:0];
      got.dir = m_tdata[9:8];
      got.car = m_tdata[17:10];
      got.tdir = m_tdata[19:18];
      got.last = m_tlast;
      n_beats++;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: res %0d floor %0d", got.res, got.floor);
      end else begin
        want = pending_events.pop_front();
        if (got != want) begin
          errors++;
          if (errors <= 10)
            $display("beat %0d mismatch: exp res %0d fl %0d dir %b car %0d td %b last %b, got res %0d fl %0d dir %b car %0d td %b last %b",
                     n_beats, want.res, want.floor, want.dir, want.car, want.tdir, want.last,
                     got.res, got.floor, got.dir, got.car, got.tdir, got.last);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  int quiet = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  row_t dir_rows[] = '{
    '{1, 8'd0,   DIR_NONE, EV_IDLE},
    '{0, 8'd1,   DIR_NONE, EV_AT_CAR},
    '{0, 8'd1,   DIR_DN,   EV_AT_CAR},
    '{0, 8'd255, DIR_UP,   EV_QUEUED},
    '{0, 8'd255, DIR_UP,   EV_DUP},
    '{0, 8'd0,   DIR_DN,   EV_QUEUED},
    '{0, 8'd0,   2'b10,    EV_DUP},
    '{0, 8'd3,   DIR_NONE, EV_QUEUED},
    '{0, 8'd3,   DIR_UP,   EV_QUEUED},
    '{0, 8'd3,   DIR_DN,   EV_QUEUED},
    '{1, 8'd0,   DIR_NONE, EV_MOVED},
    '{0, 8'd2,   DIR_DN,   -1},
    '{0, 8'd170, DIR_NONE, -1},
    '{1, 8'd0,   DIR_NONE, -1},
    '{1, 8'd255, 2'b10,    -1},
    '{0, 8'd85,  DIR_UP,   -1},
    '{1, 8'd0,   DIR_NONE, -1},
    '{1, 8'd0,   DIR_NONE, -1},
    '{0, 8'd3,   DIR_UP,   -1},
    '{1, 8'd0,   DIR_NONE, -1},
    '{1, 8'd0,   DIR_NONE, -1},
    '{0, 8'd1,   DIR_UP,   -1}
  };

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send(dir_rows[i].tick, dir_rows[i].floor, dir_rows[i].dcode,
                               dir_rows[i].want);
    set_start_floor(8'd255);
    no_idle = 1'b1;
    repeat (4) trip();
    no_idle = 1'b0;
    fill_queue();
    hold_sink = 1'b1;
    repeat (20) send(1'b0, 8'($urandom), 2'($urandom), -1);
    set_start_floor(8'd1);
    while (n_items < 200) trip();
    set_start_floor(8'($urandom_range(2, 254)));
    fill_queue();
    while (n_items < 310) trip();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("%0d items, %0d result beats: %0d stops served, %0d moves, %0d queue-full",
             n_items, n_beats, n_served, n_moves, n_full);
    $display("start floor set to 1, 255 and a random floor; one long sink hold-off");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/esched_pkg.sv
sv/esched_queue.sv
sv/elevator_stop_scheduler.sv
bench/tb_elevator_stop_scheduler.sv
